[rtl/dfn_pkg.sv]
package dfn_pkg;

   // item kinds carried on tuser
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_NAV   = 1'b1;

   // navigation directions
   localparam logic [2:0] DIR_PREV  = 3'd0;
   localparam logic [2:0] DIR_NEXT  = 3'd1;
   localparam logic [2:0] DIR_LEFT  = 3'd2;
   localparam logic [2:0] DIR_RIGHT = 3'd3;
   localparam logic [2:0] DIR_UP    = 3'd4;
   localparam logic [2:0] DIR_DOWN  = 3'd5;

   localparam int COORD_W = 12;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ORIGIN,
      ST_SCAN,
      ST_PICK,
      ST_DONE
   } dfn_state_type;

   // control from the sequencer to the candidate selector
   typedef struct packed {
      logic       load_origin;
      logic       scan_en;
      logic [2:0] dir;
   } dfn_ctrl_type;

endpackage

[rtl/dfn_best.sv]
module dfn_best import dfn_pkg::*; #(
   parameter int IDX_W = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dfn_ctrl_type         ctrl,
   input  logic [IDX_W-1:0]     cur_idx,
   input  logic [IDX_W-1:0]     cand_idx,
   input  logic [COORD_W-1:0]   rd_x,
   input  logic [COORD_W-1:0]   rd_y,
   output logic [IDX_W-1:0]     best_idx
);

   logic [COORD_W-1:0] ox_ff, ox_in;
   logic [COORD_W-1:0] oy_ff, oy_in;
   logic [COORD_W-1:0] best_prim_ff, best_prim_in;
   logic [COORD_W-1:0] best_sec_ff, best_sec_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic               found_ff, found_in;

   logic [COORD_W-1:0] dx, dy, prim, sec;
   logic               on_side, horizontal, better, take;

   // distances and side test of the candidate against the focused node
   always_comb begin
      dx = (rd_x > ox_ff) ? rd_x - ox_ff : ox_ff - rd_x;
      dy = (rd_y > oy_ff) ? rd_y - oy_ff : oy_ff - rd_y;
      horizontal = (ctrl.dir == DIR_LEFT) || (ctrl.dir == DIR_RIGHT);
      prim = horizontal ? dx : dy;
      sec  = horizontal ? dy : dx;
      case (ctrl.dir)
         DIR_LEFT:  on_side = rd_x < ox_ff;
         DIR_RIGHT: on_side = rd_x > ox_ff;
         DIR_UP:    on_side = rd_y < oy_ff;
         DIR_DOWN:  on_side = rd_y > oy_ff;
         default:   on_side = 1'b0;
      endcase
      // main axis first, then cross axis; strict less keeps the lower index
      better = !found_ff || ({prim, sec} < {best_prim_ff, best_sec_ff});
      take = ctrl.scan_en && on_side && (cand_idx != cur_idx) && better;
   end

   // origin capture and running best
   always_comb begin
      ox_in        = ox_ff;
      oy_in        = oy_ff;
      best_prim_in = best_prim_ff;
      best_sec_in  = best_sec_ff;
      best_idx_in  = best_idx_ff;
      found_in     = found_ff;
      if (ctrl.load_origin) begin
         ox_in       = rd_x;
         oy_in       = rd_y;
         best_idx_in = cur_idx;
         found_in    = 1'b0;
      end else if (take) begin
         best_prim_in = prim;
         best_sec_in  = sec;
         best_idx_in  = cand_idx;
         found_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      ox_ff        <= ox_in;
      oy_ff        <= oy_in;
      best_prim_ff <= best_prim_in;
      best_sec_ff  <= best_sec_in;
      best_idx_ff  <= best_idx_in;
   end

   assign best_idx = best_idx_ff;

endmodule

[rtl/directional_focus_navigator_top.sv]
// channel   dir   handshake              payload
// req       in    req_tvalid/req_tready  req_tdata, req_tuser (kind)
// rsp       out   rsp_tvalid/rsp_tready  rsp_tdata
// csr       in    csr_wr_en              csr_wr_data (node count)
//
// a write word is stored as it is taken; previous, next and empty-table answers go from
// idle through the done state to the response register, a directional word through the
// origin, scan, pick and done states, the single table read port scanning one entry per
// cycle; done waits for a free response register, then the next word is taken in idle.
// one word is in work at a time; a new word is taken while a response waits.
// synchronous active-high reset clears the sequencer, response valid and count;
// table contents are undefined until written.
module directional_focus_navigator_top import dfn_pkg::*; #(
   parameter int NODES = 64
) (
   input  logic        clock,
   input  logic        reset,
   // csr
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data,
   // request: tdata = entry_index[5:0], entry_x[17:6], entry_y[29:18],
   //          current_index[35:30], direction[38:36], zero[39]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic        req_tuser,   // opcode
   // response: tdata = target_index[5:0], zero[7:6]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata
);

   localparam int IDX_W = $clog2(NODES);
   localparam int CNT_W = $clog2(NODES + 1);

   // request fields
   logic [5:0]         f_entry_index;
   logic [COORD_W-1:0] f_entry_x, f_entry_y;
   logic [5:0]         f_cur;
   logic [2:0]         f_dir;

   assign f_entry_index = req_tdata[5:0];
   assign f_entry_x     = req_tdata[17:6];
   assign f_entry_y     = req_tdata[29:18];
   assign f_cur         = req_tdata[35:30];
   assign f_dir         = req_tdata[38:36];

   logic [6:0]            node_count_ff;
   dfn_state_type         state_ff, state_in;
   logic [2:0]            dir_ff, dir_in;
   logic [IDX_W-1:0]      cur_ff, cur_in;
   logic [IDX_W-1:0]      data_idx_ff, data_idx_in;
   logic [IDX_W-1:0]      result_ff, result_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [5:0]            rsp_data_ff, rsp_data_in;
   logic [2*COORD_W-1:0]  rd_data_ff;
   logic [2*COORD_W-1:0]  table_mem [NODES];

   logic [CNT_W-1:0]      count_sat;
   logic [IDX_W-1:0]      cur_clamp, prev_idx, next_idx, rd_addr, best_idx;
   logic                  accept, is_nav, is_dirn, scan_last, rsp_free, wr_en;
   dfn_ctrl_type          ctrl;

   // node count register
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= 7'd0;
      end else if (csr_wr_en) begin
         node_count_ff <= csr_wr_data;
      end
   end

   // count saturated to table depth, focus clamped, neighbours by index
   always_comb begin
      count_sat = (32'(node_count_ff) > NODES) ? CNT_W'(NODES) : CNT_W'(node_count_ff);
      cur_clamp = (32'(f_cur) > 32'(count_sat) - 1) ?
                  IDX_W'(count_sat - CNT_W'(1)) : IDX_W'(f_cur);
      prev_idx  = (cur_clamp == '0) ? IDX_W'(count_sat - CNT_W'(1)) :
                  cur_clamp - IDX_W'(1);
      next_idx  = (32'(cur_clamp) + 1 == 32'(count_sat)) ? '0 : cur_clamp + IDX_W'(1);
   end

   assign accept    = req_tvalid && req_tready;
   assign is_nav    = (req_tuser == OP_NAV);
   assign is_dirn   = (f_dir != DIR_PREV) && (f_dir != DIR_NEXT);
   assign scan_last = (32'(data_idx_ff) == 32'(count_sat) - 1);
   assign rsp_free  = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && is_nav) begin
               if ((count_sat == '0) || !is_dirn) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_ORIGIN;
               end
            end
         end
         ST_ORIGIN: state_in = ST_SCAN;
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready       = (state_ff == ST_IDLE);
      ctrl.load_origin = 1'b0;
      ctrl.scan_en     = 1'b0;
      ctrl.dir         = dir_ff;
      rd_addr          = cur_clamp;
      wr_en            = 1'b0;
      dir_in           = dir_ff;
      cur_in           = cur_ff;
      data_idx_in      = data_idx_ff;
      result_in        = result_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      rsp_data_in      = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && !is_nav) begin
               wr_en = (32'(f_entry_index) < NODES);
            end
            if (accept && is_nav) begin
               dir_in = f_dir;
               cur_in = cur_clamp;
               if (count_sat == '0) begin
                  result_in = '0;
               end else if (f_dir == DIR_PREV) begin
                  result_in = prev_idx;
               end else if (f_dir == DIR_NEXT) begin
                  result_in = next_idx;
               end
            end
         end
         ST_ORIGIN: begin
            ctrl.load_origin = 1'b1;
            rd_addr          = '0;
            data_idx_in      = '0;
         end
         ST_SCAN: begin
            ctrl.scan_en = 1'b1;
            rd_addr      = data_idx_ff + IDX_W'(1);
            data_idx_in  = data_idx_ff + IDX_W'(1);
         end
         ST_PICK: begin
            result_in = best_idx;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = 6'(result_ff);
            end
         end
         default: ;
      endcase
   end

   // coordinate table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[IDX_W'(f_entry_index)] <= {f_entry_y, f_entry_x};
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dir_ff      <= dir_in;
      cur_ff      <= cur_in;
      data_idx_ff <= data_idx_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

   dfn_best #(
      .IDX_W (IDX_W)
   ) u_best (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .cur_idx  (cur_ff),
      .cand_idx (data_idx_ff),
      .rd_x     (rd_data_ff[COORD_W-1:0]),
      .rd_y     (rd_data_ff[2*COORD_W-1:COORD_W]),
      .best_idx (best_idx)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};

   // a scan never runs on an empty table
   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (count_sat != '0))
      else $error("scan with empty table");

   // the scan index never passes the last valid entry
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (32'(data_idx_ff) < 32'(count_sat)))
      else $error("scan index beyond count");

   // a response is only loaded out of the done state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("response raised outside done state");

   // a finished answer is always a valid node, or zero on an empty table
   a_result_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |->
         ((32'(result_ff) < 32'(count_sat)) || (result_ff == '0)))
      else $error("result index out of range");

endmodule

[tb/directional_focus_navigator_top_tb.sv]
`timescale 1ns / 1ps

module directional_focus_navigator_top_tb;
   import dfn_pkg::*;

   localparam int NODE_DEPTH    = 64;
   localparam int SETTLE_CYCLES = 80;    // longest directional scan plus margin
   localparam int PHASE_WORDS   = 46;
   localparam int MAX_REPORTS   = 10;

   // directions the block does not define
   localparam logic [2:0] DIR_SPARE_LO = 3'd6;
   localparam logic [2:0] DIR_SPARE_HI = 3'd7;

   typedef enum logic { ROW_WORD, ROW_CSR } row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic         op;
      logic [5:0]   entry;
      logic [11:0]  pos_x;
      logic [11:0]  pos_y;
      logic [5:0]   focus;
      logic [2:0]   dir;
      logic [6:0]   count;
      bit           known;
      logic [5:0]   target;
   } nav_row_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [6:0]  csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;

   // own copy of the block state
   logic [11:0] shadow_x [NODE_DEPTH];
   logic [11:0] shadow_y [NODE_DEPTH];
   bit          shadow_written [NODE_DEPTH];
   logic [6:0]  shadow_count;

   logic [5:0]  target_q [$];
   nav_row_type directed_rows [$];
   int          fail_count;
   bit          send_burst;
   logic [5:0]  got_target;

   directional_focus_navigator_top #(.NODES(NODE_DEPTH)) dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   // clock
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   // number of live nodes, saturated at the table depth
   function automatic int live_nodes();
      return (shadow_count > NODE_DEPTH) ? NODE_DEPTH : int'(shadow_count);
   endfunction

   function automatic int abs_gap(logic [11:0] a, logic [11:0] b);
      return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
   endfunction

   // focus target for one navigate word
   function automatic logic [5:0] pick_target(logic [5:0] focus, logic [2:0] dir);
      int         live;
      int         here;
      int         best;
      int         main_d;
      int         cross_d;
      int         best_main;
      int         best_cross;
      bit         horiz;
      bit         hit;
      logic [11:0] ox;
      logic [11:0] oy;
      live = live_nodes();
      if (live == 0) return 6'd0;
      here = (int'(focus) > live - 1) ? live - 1 : int'(focus);
      if (dir == DIR_PREV) return (here == 0) ? 6'(live - 1) : 6'(here - 1);
      if (dir == DIR_NEXT) return (here + 1 == live) ? 6'd0 : 6'(here + 1);
      if (dir > DIR_DOWN) return 6'(here);
      ox = shadow_x[here];
      oy = shadow_y[here];
      horiz = (dir == DIR_LEFT) || (dir == DIR_RIGHT);
      best = here;
      best_main = -1;
      best_cross = -1;
      for (int i = 0; i < live; i++) begin
         if (i == here) continue;
         hit = (dir == DIR_LEFT  && shadow_x[i] < ox) || (dir == DIR_RIGHT && shadow_x[i] > ox) ||
               (dir == DIR_UP    && shadow_y[i] < oy) || (dir == DIR_DOWN  && shadow_y[i] > oy);
         if (!hit) continue;
         main_d  = horiz ? abs_gap(shadow_x[i], ox) : abs_gap(shadow_y[i], oy);
         cross_d = horiz ? abs_gap(shadow_y[i], oy) : abs_gap(shadow_x[i], ox);
         // strict compare keeps the lower index on a full tie
         if (best_main < 0 || main_d < best_main ||
             (main_d == best_main && cross_d < best_cross)) begin
            best_main = main_d;
            best_cross = cross_d;
            best = i;
         end
      end
      return 6'(best);
   endfunction

   // every live entry has been loaded
   function automatic bit live_loaded();
      for (int i = 0; i < live_nodes(); i++)
         if (!shadow_written[i]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [11:0] draw_coord();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
         1: return 12'($urandom_range(0, 15) * 256);
         default: return 12'($urandom_range(0, 4095));
      endcase
   endfunction

   function automatic nav_row_type word_row(logic op, logic [5:0] entry, logic [11:0] px,
                                            logic [11:0] py, logic [5:0] focus,
                                            logic [2:0] dir, bit known, logic [5:0] target);
      nav_row_type r;
      r.kind = ROW_WORD;
      r.op = op;
      r.entry = entry;
      r.pos_x = px;
      r.pos_y = py;
      r.focus = focus;
      r.dir = dir;
      r.count = '0;
      r.known = known;
      r.target = target;
      return r;
   endfunction

   function automatic nav_row_type csr_row(logic [6:0] count);
      nav_row_type r;
      r = word_row(OP_WRITE, '0, '0, '0, '0, '0, 1'b0, '0);
      r.kind = ROW_CSR;
      r.count = count;
      return r;
   endfunction

   // append one row to the directed table
   function automatic void add_row(nav_row_type r);
      directed_rows = {directed_rows, r};
   endfunction

   // send one word; entered and left at a falling edge
   task automatic send_word(nav_row_type r);
      int         gap;
      logic [5:0] want;
      gap = send_burst ? 0 : $urandom_range(0, 16);
      want = r.known ? r.target : pick_target(r.focus, r.dir);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  <= r.op;
      req_tdata  <= {1'b0, r.dir, r.focus, r.pos_y, r.pos_x, r.entry};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (r.op == OP_NAV) begin
         target_q = {target_q, want};
      end else begin
         shadow_x[r.entry] = r.pos_x;
         shadow_y[r.entry] = r.pos_y;
         shadow_written[r.entry] = 1'b1;
      end
      @(negedge clock);
   endtask

   // stop sending and wait for every pending answer
   task automatic drain(bit settle);
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (target_q.size() != 0) @(negedge clock);
      if (settle) repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_count(logic [6:0] count);
      drain(1'b1);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= count;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      shadow_count = count;
   endtask

   // one random word, kept well formed so that no unloaded entry is read
   function automatic nav_row_type random_row();
      int live;
      int hole;
      live = live_nodes();
      if ($urandom_range(0, 3) == 0) begin
         return word_row(OP_WRITE,
                         (live > 0 && $urandom_range(0, 1)) ? 6'($urandom_range(0, live - 1))
                                                            : 6'($urandom_range(0, 63)),
                         draw_coord(), draw_coord(), 6'($urandom), 3'($urandom), 1'b0, '0);
      end
      if (!live_loaded()) begin
         hole = 0;
         while (shadow_written[hole]) hole++;
         return word_row(OP_WRITE, 6'(hole), draw_coord(), draw_coord(),
                         6'($urandom), 3'($urandom), 1'b0, '0);
      end
      return word_row(OP_NAV, 6'($urandom), 12'($urandom), 12'($urandom),
                      (live > 0 && $urandom_range(0, 4) != 0) ? 6'($urandom_range(0, live - 1))
                                                              : 6'($urandom_range(0, 63)),
                      ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                                  : 3'($urandom_range(0, 5)),
                      1'b0, '0);
   endfunction

   // response sink with random stalls and stall-free stretches
   initial begin
      int stall;
      int taken;
      taken = 0;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         stall = ((taken / 50) % 2 == 1) ? 0 : $urandom_range(0, 16);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         taken++;
         @(negedge clock);
      end
   end

   // answer checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (target_q.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("unexpected word: target %0d", rsp_tdata[5:0]);
         end else begin
            got_target = target_q.pop_front();
            if (rsp_tdata[5:0] !== got_target) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("target mismatch: expected %0d, got %0d",
                           got_target, rsp_tdata[5:0]);
            end
         end
      end
   end

   // stimulus
   initial begin
      logic [6:0] phase_counts [12];
      fail_count  = 0;
      send_burst  = 1'b0;
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = OP_WRITE;
      shadow_count = '0;
      for (int i = 0; i < NODE_DEPTH; i++) begin
         shadow_x[i] = '0;
         shadow_y[i] = '0;
         shadow_written[i] = 1'b0;
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty table, wrap, clamp, each side, no candidate, ties
      add_row(word_row(OP_NAV, 6'd0, 12'd0, 12'd0, 6'd0, DIR_NEXT, 1'b1, 6'd0));
      add_row(word_row(OP_NAV, 6'd63, 12'hFFF, 12'hFFF, 6'd63, DIR_UP, 1'b1, 6'd0));
      add_row(word_row(OP_WRITE, 6'd0, 12'd2048, 12'd2048, 6'd0, 3'd0, 1'b0, 6'd0));
      add_row(word_row(OP_WRITE, 6'd1, 12'd0, 12'd2048, 6'd0, 3'd0, 1'b0, 6'd0));
      add_row(word_row(OP_WRITE, 6'd2, 12'hFFF, 12'd2048, 6'd0, 3'd0, 1'b0, 6'd0));
      add_row(word_row(OP_WRITE, 6'd3, 12'd2048, 12'd0, 6'd0, 3'd0, 1'b0, 6'd0));
      add_row(word_row(OP_WRITE, 6'd4, 12'd2048, 12'hFFF, 6'd0, 3'd0, 1'b0, 6'd0));
      add_row(word_row(OP_WRITE, 6'd5, 12'd0, 12'd2048, 6'd0, 3'd0, 1'b0, 6'd0));
      add_row(csr_row(7'd6));
      add_row(word_row(OP_NAV, 6'd0, 12'd0, 12'd0, 6'd63, DIR_PREV, 1'b1, 6'd4));
      add_row(word_row(OP_NAV, 6'd0, 12'd0, 12'd0, 6'd5, DIR_NEXT, 1'b1, 6'd0));
      add_row(word_row(OP_NAV, 6'd0, 12'd0, 12'd0, 6'd0, DIR_PREV, 1'b1, 6'd5));
      add_row(word_row(OP_NAV, 6'd0, 12'd0, 12'd0, 6'd0, DIR_LEFT, 1'b0, 6'd0));
      add_row(word_row(OP_NAV, 6'd0, 12'd0, 12'd0, 6'd0, DIR_RIGHT, 1'b0, 6'd0));
      add_row(word_row(OP_NAV, 6'd0, 12'd0, 12'd0, 6'd0, DIR_UP, 1'b0, 6'd0));
      add_row(word_row(OP_NAV, 6'd0, 12'd0, 12'd0, 6'd0, DIR_DOWN, 1'b0, 6'd0));
      add_row(word_row(OP_NAV, 6'd0, 12'd0, 12'd0, 6'd1, DIR_LEFT, 1'b1, 6'd1));
      add_row(word_row(OP_NAV, 6'd0, 12'd0, 12'd0, 6'd0, DIR_SPARE_LO, 1'b1, 6'd0));
      add_row(word_row(OP_NAV, 6'd0, 12'd0, 12'd0, 6'd63, DIR_SPARE_HI, 1'b1, 6'd5));
      add_row(word_row(OP_WRITE, 6'd63, 12'hFFF, 12'hFFF, 6'd0, 3'd0, 1'b0, 6'd0));
      add_row(csr_row(7'd1));
      add_row(word_row(OP_NAV, 6'd0, 12'd0, 12'd0, 6'd0, DIR_LEFT, 1'b1, 6'd0));
      add_row(word_row(OP_NAV, 6'd0, 12'd0, 12'd0, 6'd40, DIR_NEXT, 1'b1, 6'd0));

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) write_count(directed_rows[i].count);
         else send_word(directed_rows[i]);
      end

      // random phases over several table sizes, extremes among them
      phase_counts = '{7'd3, 7'd0, 7'd12, 7'd1, 7'd64, 7'd127, 7'd2, 7'd40, 7'd65, 7'd7,
                       7'd20, 7'd0};
      phase_counts[11] = 7'($urandom_range(2, 30));
      for (int p = 0; p < 12; p++) begin
         write_count(phase_counts[p]);
         send_burst = (p % 3 == 1);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            send_word(random_row());
            // occasional hold-off until the block has answered everything
            if ($urandom_range(0, 39) == 0) drain(1'b0);
         end
      end

      drain(1'b1);
      if (fail_count == 0 && target_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
